// File: hdl/pet_pkg.sv
// ---------------------------------------------------------------------------
// Path expression tokenizer package
// Token kinds, error codes, index codes, character constants, the flag state
// type and the result item type shared by the tokenizer top level and its step logic.
// ---------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

   // Token kinds reported with each result
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_FIELD = 2'd1;
   localparam logic [1:0] KIND_INT   = 2'd2;
   localparam logic [1:0] KIND_STR   = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_CHAR       = 3'd1;
   localparam logic [2:0] ERR_DOT        = 3'd2;
   localparam logic [2:0] ERR_OPEN       = 3'd3;
   localparam logic [2:0] ERR_CLOSE      = 3'd4;
   localparam logic [2:0] ERR_NUMBER     = 3'd5;
   localparam logic [2:0] ERR_COMPLETION = 3'd6;

   // Index classification codes
   localparam logic [1:0] IDX_EMPTY = 2'd0;
   localparam logic [1:0] IDX_NUM   = 2'd1;
   localparam logic [1:0] IDX_STR   = 2'd2;
   localparam logic [1:0] IDX_BAD   = 2'd3;

   // Path punctuation
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Flag state of the tokenizer (the token length travels beside it)
   typedef struct packed {
      logic       inside_brackets;
      logic       just_ended_field;
      logic       just_ended_index;
      logic       at_path_start;
      logic       previous_was_dot;
      logic [1:0] index_numeric_so_far;
      logic [2:0] held_error;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{
      inside_brackets:      1'b0,
      just_ended_field:     1'b0,
      just_ended_index:     1'b0,
      at_path_start:        1'b1,
      previous_was_dot:     1'b0,
      index_numeric_so_far: IDX_EMPTY,
      held_error:           ERR_NONE
   };

   // One result item
   typedef struct packed {
      logic [1:0] token_kind;
      logic [7:0] token_length;
      logic [2:0] error_code;
      logic       path_end;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/pet_step.sv
// ---------------------------------------------------------------------------
// Path expression tokenizer step logic
// Combinational update for one character: classifies it, advances the flag
// state and token length, and forms the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module pet_step
   import pet_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int LEN_WIDTH     = 8
) (
   input  wire logic [7:0]           ch,
   input  wire logic                 last,
   input  wire flags_type            flags,
   input  wire logic [LEN_WIDTH-1:0] cur_len,
   output flags_type                 flags_next,
   output logic [LEN_WIDTH-1:0]      cur_len_next,
   output result_type                result
);

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = LEN_WIDTH'(MAX_TOKEN_LEN);
   localparam logic [LEN_WIDTH-1:0] LEN_ZERO = '0;

   logic                 is_digit;
   logic                 is_word;
   logic [1:0]           kind;
   logic [LEN_WIDTH-1:0] len;
   logic [2:0]           err;
   logic [15:0]          len_wide;
   flags_type            f;
   logic [LEN_WIDTH-1:0] n;

   // Character classes
   assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
   assign is_word  = is_digit || ((ch >= 8'h41) && (ch <= 8'h5A))
                     || ((ch >= 8'h61) && (ch <= 8'h7A))
                     || (ch == CH_UNDER) || (ch == CH_MINUS);

   // Character handling and end-of-path check
   always_comb begin
      f    = flags;
      n    = cur_len;
      kind = KIND_NONE;
      len  = LEN_ZERO;
      err  = flags.held_error;
      if (flags.held_error == ERR_NONE) begin
         if (!is_word && (ch != CH_LBRACK) && (ch != CH_RBRACK) && (ch != CH_DOT)) begin
            err = ERR_CHAR;
         end else if (ch == CH_DOT) begin
            if (flags.inside_brackets) begin
               err = ERR_DOT;
            end else if (cur_len != LEN_ZERO) begin
               if (flags.just_ended_index) begin
                  err = ERR_DOT;
               end else begin
                  kind = KIND_FIELD;
                  len  = cur_len;
               end
            end else if (!flags.just_ended_index || flags.at_path_start
                         || flags.previous_was_dot) begin
               err = ERR_DOT;
            end
            f.just_ended_field = 1'b1;
            f.just_ended_index = 1'b0;
            n = LEN_ZERO;
         end else if (ch == CH_LBRACK) begin
            if (flags.inside_brackets || flags.just_ended_field) begin
               err = ERR_OPEN;
            end else begin
               kind = KIND_FIELD;
               len  = cur_len;
               f.inside_brackets      = 1'b1;
               n                      = LEN_ZERO;
               f.index_numeric_so_far = IDX_EMPTY;
            end
         end else if (ch == CH_RBRACK) begin
            if (!flags.inside_brackets || flags.just_ended_field || (cur_len == LEN_ZERO)) begin
               err = ERR_CLOSE;
            end else if (flags.index_numeric_so_far == IDX_BAD) begin
               err = ERR_NUMBER;
            end else begin
               kind = (flags.index_numeric_so_far == IDX_NUM) ? KIND_INT : KIND_STR;
               len  = cur_len;
               f.inside_brackets  = 1'b0;
               n                  = LEN_ZERO;
               f.just_ended_index = 1'b1;
            end
         end else begin
            f.just_ended_field = 1'b0;
            if (flags.inside_brackets) begin
               if (cur_len == LEN_ZERO) begin
                  f.index_numeric_so_far = (is_digit || (ch == CH_MINUS)) ? IDX_NUM : IDX_STR;
               end else if ((flags.index_numeric_so_far == IDX_NUM) && !is_digit) begin
                  f.index_numeric_so_far = IDX_BAD;
               end
            end
            if (cur_len < LEN_MAX) begin
               n = cur_len + 1'b1;
            end
         end
         f.previous_was_dot = (ch == CH_DOT);
         f.at_path_start    = 1'b0;

         // The last character closes the path and emits a pending field
         if ((err == ERR_NONE) && last) begin
            if (f.just_ended_field || f.inside_brackets) begin
               err = ERR_COMPLETION;
            end else if (n != LEN_ZERO) begin
               kind = KIND_FIELD;
               len  = n;
            end
         end
         f.held_error = err;
      end

      // An error result carries no token
      if (err != ERR_NONE) begin
         kind = KIND_NONE;
         len  = LEN_ZERO;
      end

      // The end of a path returns everything to the reset state
      if (last) begin
         f = FLAGS_RESET;
         n = LEN_ZERO;
      end
   end

   // Reported length saturates at the width of the length field
   assign len_wide = 16'(len);

   assign flags_next          = f;
   assign cur_len_next        = n;
   assign result.token_kind   = kind;
   assign result.token_length = (len_wide > 16'd255) ? 8'hFF : len_wide[7:0];
   assign result.error_code   = err;
   assign result.path_end     = last;

endmodule

`default_nettype wire

// File: hdl/path_expression_tokenizer.sv
// ---------------------------------------------------------------------------
// Path expression tokenizer
// Checks a document path one character per transfer and reports each
// completed token (field name, integer index, string index) or an error.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one path character per transfer in
//   req_tdata[7:0]; req_tlast marks the final character of the path.
//   Every accepted character gives exactly one transfer on the rsp_
//   channel, in order: token kind, token length and error code in
//   rsp_tdata, with rsp_tlast copying the path end flag.
//   The result of an accepted character is registered and offered on
//   rsp_ in the cycle after it is accepted. Throughput is one character
//   per cycle while the receiver keeps rsp_tready high, set by the single
//   result register behind the per-character flag logic.
//   When the receiver stalls, the result register holds its item and
//   req_tready falls until that result is taken; nothing is lost.
//   Reset clears the tokenizer state to the start of a path and empties
//   the result register. Errors are held until the last character of the
//   path, after which the state starts afresh.
// ---------------------------------------------------------------------------
`default_nettype none

module path_expression_tokenizer
   import pet_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [1:0] token_kind, [9:2] token_length,
                                         // [12:10] error_code, [15:13] zero
   output logic             rsp_tlast
);

   localparam int LEN_WIDTH = $clog2(MAX_TOKEN_LEN + 1);

   flags_type            flags_ff, flags_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   result_type           result_ff, result_in;
   logic                 valid_ff, valid_in;
   logic                 req_fire;

   // A new character enters whenever the result register is free or draining
   assign req_tready = !valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   pet_step #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .LEN_WIDTH     (LEN_WIDTH)
   ) u_step (
      .ch           (req_tdata),
      .last         (req_tlast),
      .flags        (flags_ff),
      .cur_len      (len_ff),
      .flags_next   (flags_in),
      .cur_len_next (len_in),
      .result       (result_in)
   );

   // Result register valid flag
   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Tokenizer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req_fire) begin
            flags_ff <= flags_in;
            len_ff   <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.error_code, result_ff.token_length,
                        result_ff.token_kind};
   assign rsp_tlast  = result_ff.path_end;

   // An error result never carries a token
   a_error_no_token: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (result_ff.error_code != ERR_NONE))
      |-> ((result_ff.token_kind == KIND_NONE) && (result_ff.token_length == 8'd0)))
      else $error("error result carries a token");

   // No token kind means no length
   a_none_zero_len: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (result_ff.token_kind == KIND_NONE)) |-> (result_ff.token_length == 8'd0))
      else $error("length reported without a token");

   // The last character of a path returns the state to the start of a path
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast)
      |=> ((flags_ff == FLAGS_RESET) && (len_ff == '0) && result_ff.path_end))
      else $error("state not cleared after the end of a path");

   // Input is held off only while a finished result waits
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid_ff && !rsp_tready))
      else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
